@@ hdl/gif_lzw_encoder_assert.svh @@
// assertion macros shared by the output queue and the datapath
`ifndef GIF_LZW_ENCODER_ASSERT_SVH
`define GIF_LZW_ENCODER_ASSERT_SVH

// property checked at every clock edge outside reset
`define GLE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// antecedent followed by a consequent in the next cycle
`define GLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/gle_pkg.sv @@
// types, constants and command/status structs of the gif lzw encoder
package gle_pkg;

  localparam int unsigned DICT_SLOTS = 8192;
  localparam int unsigned OUT_DEPTH  = 4;

  localparam logic [19:0] EMPTY_KEY = 20'hFFFFF;
  localparam logic [12:0] MAX_CODE  = 13'd4095;
  localparam logic [3:0]  MAX_WIDTH = 4'd12;
  localparam logic [3:0]  DEPTH_MIN = 4'd2;
  localparam logic [3:0]  DEPTH_MAX = 4'd8;
  localparam logic [3:0]  DEPTH_RST = 4'd8;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_PIXEL  = 2'd1,
    OP_FINISH = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    CS_PREFIX = 2'd0,
    CS_CLEAR  = 2'd1,
    CS_END    = 2'd2
  } code_sel_e;

  typedef enum logic [4:0] {
    PH_START      = 5'b00001,
    PH_MISS_PREF  = 5'b00010,
    PH_MISS_CLR   = 5'b00100,
    PH_FIN_PREF   = 5'b01000,
    PH_FIN_END    = 5'b10000
  } phase_e;

  typedef struct packed {
    logic      latch;
    logic      start_img;
    logic      put_code;
    code_sel_e code_sel;
    logic      emit_depth;
    logic      drain;
    logic      grow;
    logic      set_prefix_pix;
    logic      set_prefix_hit;
    logic      probe_start;
    logic      probe_next;
    logic      probe_miss;
    logic      dict_add;
    logic      restart;
    logic      clr_step;
    logic      fin_cleanup;
    logic      flush;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       active;
    logic       prefix_valid;
    logic       bc_ge8;
    logic       bc_nz;
    logic       emit_stall;
    logic       fifo_full;
    logic       pend_valid;
    logic       hit;
    logic       empty;
    logic       exhausted;
    logic       nfc_full;
    logic       clr_last;
  } sts_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_last;
    logic       end_of_image;
  } out_entry_t;

endpackage

@@ hdl/gle_if.sv @@
// channel interfaces of the gif lzw encoder
interface gle_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] pixel_value;
  modport source (output valid, opcode, pixel_value, input ready);
  modport sink (input valid, opcode, pixel_value, output ready);
endinterface

interface gle_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_last;
  logic       end_of_image;
  modport source (output valid, out_byte, is_last, end_of_image, input ready);
  modport sink (input valid, out_byte, is_last, end_of_image, output ready);
endinterface

interface gle_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] min_code_size;
  modport source (output valid, min_code_size, input ready);
  modport sink (input valid, min_code_size, output ready);
endinterface

@@ hdl/gle_out_fifo.sv @@
// small output queue holding packed bytes until the consumer takes them
`include "gif_lzw_encoder_assert.svh"
module gle_out_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  gle_pkg::out_entry_t push_data_i,
  output logic                full_o,
  output logic                valid_o,
  input  logic                ready_i,
  output gle_pkg::out_entry_t data_o
);

  localparam int unsigned AW = $clog2(gle_pkg::OUT_DEPTH);
  localparam int unsigned CW = $clog2(gle_pkg::OUT_DEPTH + 1);

  gle_pkg::out_entry_t mem_q [gle_pkg::OUT_DEPTH];
  logic [AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == CW'(gle_pkg::OUT_DEPTH));
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == AW'(gle_pkg::OUT_DEPTH - 1)) ? '0 : wr_q + AW'(1);
    end
    if (pop) begin
      rd_d = (rd_q == AW'(gle_pkg::OUT_DEPTH - 1)) ? '0 : rd_q + AW'(1);
    end
    if (push_i && !pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (!push_i && pop) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  `GLE_ASSERT(a_no_overflow, push_i |-> !full_o, "push into full output queue")
  `GLE_ASSERT_NEXT(a_pop_count, pop && !push_i, cnt_q == $past(cnt_q) - CW'(1), "pop miscounted")
  `GLE_ASSERT(a_count_range, cnt_q <= CW'(gle_pkg::OUT_DEPTH), "queue count out of range")

endmodule

@@ hdl/gle_datapath.sv @@
// dictionary memory, code registers and bit packer of the encoder
`include "gif_lzw_encoder_assert.svh"
module gle_datapath #(
  parameter int unsigned DictSlots = gle_pkg::DICT_SLOTS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [3:0]          min_code_size_i,
  input  logic                cfg_we_i,
  input  logic [1:0]          opcode_i,
  input  logic [7:0]          pixel_value_i,
  input  gle_pkg::cmd_t       cmd_i,
  output gle_pkg::sts_t       sts_o,
  input  logic                fifo_full_i,
  output logic                push_o,
  output gle_pkg::out_entry_t push_data_o
);

  localparam int unsigned SW = $clog2(DictSlots);

  logic [31:0] mem [DictSlots];
  logic [31:0] rd_q;

  logic [3:0]    cfg_q;
  logic [3:0]    depth_q, depth_d;
  logic          active_q, active_d;
  logic [11:0]   prefix_q, prefix_d;
  logic          pv_q, pv_d;
  logic [12:0]   nfc_q, nfc_d;
  logic [3:0]    cw_q, cw_d;
  logic [12:0]   wl_q, wl_d;
  logic [19:0]   acc_q, acc_d;
  logic [4:0]    bc_q, bc_d;
  logic [1:0]    op_q;
  logic [7:0]    pix_q;
  logic [19:0]   key_q, key_d;
  logic [SW-1:0] slot_q, slot_d;
  logic [SW-1:0] n_q, n_d;
  logic          add_ok_q, add_ok_d;
  logic [7:0]    pend_q, pend_d;
  logic          pend_v_q, pend_v_d;
  logic [SW-1:0] clr_q;

  logic [3:0]  depth_clamp, rs_depth;
  logic [7:0]  pixm;
  logic [19:0] key_w, hash_w;
  logic [11:0] clr_val, code_val;
  logic        emit;
  logic [7:0]  emit_byte;
  logic        we;
  logic [SW-1:0] waddr;
  logic [31:0] wdata;

  assign depth_clamp = (cfg_q < gle_pkg::DEPTH_MIN) ? gle_pkg::DEPTH_MIN :
                       (cfg_q > gle_pkg::DEPTH_MAX) ? gle_pkg::DEPTH_MAX : cfg_q;
  assign rs_depth    = cmd_i.start_img ? depth_clamp : depth_q;
  assign pixm        = pix_q & ~(8'hFF << depth_q);
  assign key_w       = {prefix_q, pixm};
  assign hash_w      = key_w ^ (key_w >> 12);
  assign clr_val     = 12'd1 << depth_q;

  always_comb begin
    case (cmd_i.code_sel)
      gle_pkg::CS_PREFIX: code_val = prefix_q;
      gle_pkg::CS_CLEAR:  code_val = clr_val;
      gle_pkg::CS_END:    code_val = clr_val + 12'd1;
      default:            code_val = prefix_q;
    endcase
  end

  assign emit      = cmd_i.emit_depth || cmd_i.drain;
  assign emit_byte = cmd_i.emit_depth ? {4'd0, depth_q} : acc_q[7:0];

  assign push_o = (emit && pend_v_q) || cmd_i.flush;
  assign push_data_o = '{out_byte: pend_q, is_last: cmd_i.flush,
                         end_of_image: cmd_i.flush && (op_q == gle_pkg::OP_FINISH)};

  always_comb begin
    depth_d  = depth_q;
    active_d = active_q;
    prefix_d = prefix_q;
    pv_d     = pv_q;
    nfc_d    = nfc_q;
    cw_d     = cw_q;
    wl_d     = wl_q;
    acc_d    = acc_q;
    bc_d     = bc_q;
    key_d    = key_q;
    slot_d   = slot_q;
    n_d      = n_q;
    add_ok_d = add_ok_q;
    pend_d   = pend_q;
    pend_v_d = pend_v_q;
    if (cmd_i.start_img) begin
      depth_d  = depth_clamp;
      active_d = 1'b1;
      prefix_d = '0;
      pv_d     = 1'b0;
      acc_d    = '0;
      bc_d     = '0;
    end
    if (cmd_i.put_code) begin
      acc_d = acc_q | (20'(code_val) << bc_q);
      bc_d  = bc_q + 5'(cw_q);
    end
    if (cmd_i.drain) begin
      acc_d = acc_q >> 8;
      bc_d  = (bc_q >= 5'd8) ? bc_q - 5'd8 : 5'd0;
    end
    if (emit) begin
      pend_d   = emit_byte;
      pend_v_d = 1'b1;
    end
    if (cmd_i.flush) begin
      pend_v_d = 1'b0;
    end
    if (cmd_i.grow && (nfc_q >= wl_q) && (cw_q < gle_pkg::MAX_WIDTH)) begin
      cw_d = cw_q + 4'd1;
      wl_d = 13'd1 << (cw_q + 4'd1);
    end
    if (cmd_i.start_img || cmd_i.restart) begin
      nfc_d = (13'd1 << rs_depth) + 13'd2;
      cw_d  = rs_depth + 4'd1;
      wl_d  = 13'd1 << (rs_depth + 4'd1);
    end
    if (cmd_i.set_prefix_pix) begin
      prefix_d = {4'd0, pixm};
      pv_d     = 1'b1;
    end
    if (cmd_i.set_prefix_hit) begin
      prefix_d = rd_q[11:0];
    end
    if (cmd_i.probe_start) begin
      key_d  = key_w;
      slot_d = hash_w[SW-1:0];
      n_d    = '0;
    end
    if (cmd_i.probe_next) begin
      slot_d = slot_q + SW'(1);
      n_d    = n_q + SW'(1);
    end
    if (cmd_i.probe_miss) begin
      add_ok_d = (rd_q[31:12] == gle_pkg::EMPTY_KEY);
    end
    if (cmd_i.dict_add) begin
      nfc_d = nfc_q + 13'd1;
    end
    if (cmd_i.fin_cleanup) begin
      acc_d    = '0;
      bc_d     = '0;
      pv_d     = 1'b0;
      active_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q    <= gle_pkg::DEPTH_RST;
      depth_q  <= '0;
      active_q <= 1'b0;
      prefix_q <= '0;
      pv_q     <= 1'b0;
      nfc_q    <= '0;
      cw_q     <= '0;
      wl_q     <= '0;
      acc_q    <= '0;
      bc_q     <= '0;
      pend_v_q <= 1'b0;
      clr_q    <= '0;
    end else begin
      depth_q  <= depth_d;
      active_q <= active_d;
      prefix_q <= prefix_d;
      pv_q     <= pv_d;
      nfc_q    <= nfc_d;
      cw_q     <= cw_d;
      wl_q     <= wl_d;
      acc_q    <= acc_d;
      bc_q     <= bc_d;
      pend_v_q <= pend_v_d;
      if (cfg_we_i) begin
        cfg_q <= min_code_size_i;
      end
      if (cmd_i.clr_step) begin
        clr_q <= clr_q + SW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    slot_q   <= slot_d;
    n_q      <= n_d;
    add_ok_q <= add_ok_d;
    pend_q   <= pend_d;
    if (cmd_i.latch) begin
      op_q  <= opcode_i;
      pix_q <= pixel_value_i;
    end
  end

  // dictionary memory: one write port, one registered read
  assign we    = cmd_i.clr_step || (cmd_i.dict_add && add_ok_q);
  assign waddr = cmd_i.clr_step ? clr_q : slot_q;
  assign wdata = cmd_i.clr_step ? '1 : {key_q, nfc_q[11:0]};

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[slot_q];
  end

  assign sts_o = '{
    op:           op_q,
    active:       active_q,
    prefix_valid: pv_q,
    bc_ge8:       (bc_q >= 5'd8),
    bc_nz:        (bc_q != 5'd0),
    emit_stall:   pend_v_q && fifo_full_i,
    fifo_full:    fifo_full_i,
    pend_valid:   pend_v_q,
    hit:          (rd_q[31:12] == key_q),
    empty:        (rd_q[31:12] == gle_pkg::EMPTY_KEY),
    exhausted:    (n_q == '1),
    nfc_full:     (nfc_q >= gle_pkg::MAX_CODE),
    clr_last:     (clr_q == '1)
  };

  `GLE_ASSERT(a_bc_range, bc_q <= 5'd19, "bit count out of range")
  `GLE_ASSERT(a_width_range, !active_q || (cw_q >= 4'd3 && cw_q <= gle_pkg::MAX_WIDTH), "code width out of range")
  `GLE_ASSERT(a_flush_pending, cmd_i.flush |-> pend_v_q, "flush without a pending byte")

endmodule

@@ hdl/gle_ctrl.sv @@
// sequencing state machine of the encoder
module gle_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output gle_pkg::cmd_t cmd_o,
  input  gle_pkg::sts_t sts_i
);

  typedef enum logic [10:0] {
    ST_CLEAR = 11'b00000000001,
    ST_IDLE  = 11'b00000000010,
    ST_DEC   = 11'b00000000100,
    ST_DEPTH = 11'b00000001000,
    ST_PUT   = 11'b00000010000,
    ST_DRAIN = 11'b00000100000,
    ST_PROBE = 11'b00001000000,
    ST_CHECK = 11'b00010000000,
    ST_ADD   = 11'b00100000000,
    ST_RESID = 11'b01000000000,
    ST_FLUSH = 11'b10000000000
  } state_e;

  state_e             state_q, state_d;
  gle_pkg::phase_e    phase_q, phase_d;
  gle_pkg::code_sel_e csel_q, csel_d;
  logic               need_clr_q, need_clr_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    csel_d     = csel_q;
    need_clr_d = need_clr_q;
    cmd_o      = '0;
    cmd_o.code_sel = csel_q;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          need_clr_d = 1'b0;
          state_d    = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_DEC;
        end
      end
      ST_DEC: begin
        case (sts_i.op)
          gle_pkg::OP_START: begin
            cmd_o.start_img = 1'b1;
            need_clr_d      = 1'b1;
            state_d         = ST_DEPTH;
          end
          gle_pkg::OP_PIXEL: begin
            if (!sts_i.active) begin
              state_d = ST_IDLE;
            end else if (!sts_i.prefix_valid) begin
              cmd_o.set_prefix_pix = 1'b1;
              state_d = ST_IDLE;
            end else begin
              cmd_o.probe_start = 1'b1;
              state_d = ST_PROBE;
            end
          end
          gle_pkg::OP_FINISH: begin
            if (!sts_i.active) begin
              state_d = ST_IDLE;
            end else if (sts_i.prefix_valid) begin
              csel_d  = gle_pkg::CS_PREFIX;
              phase_d = gle_pkg::PH_FIN_PREF;
              state_d = ST_PUT;
            end else begin
              csel_d  = gle_pkg::CS_END;
              phase_d = gle_pkg::PH_FIN_END;
              state_d = ST_PUT;
            end
          end
          default: state_d = ST_IDLE;
        endcase
      end
      ST_DEPTH: begin
        if (!sts_i.emit_stall) begin
          cmd_o.emit_depth = 1'b1;
          csel_d  = gle_pkg::CS_CLEAR;
          phase_d = gle_pkg::PH_START;
          state_d = ST_PUT;
        end
      end
      ST_PUT: begin
        cmd_o.put_code = 1'b1;
        state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (sts_i.bc_ge8) begin
          if (!sts_i.emit_stall) begin
            cmd_o.drain = 1'b1;
          end
        end else begin
          cmd_o.grow = 1'b1;
          case (phase_q)
            gle_pkg::PH_START: state_d = ST_FLUSH;
            gle_pkg::PH_MISS_PREF: begin
              cmd_o.set_prefix_pix = 1'b1;
              if (sts_i.nfc_full) begin
                csel_d  = gle_pkg::CS_CLEAR;
                phase_d = gle_pkg::PH_MISS_CLR;
                state_d = ST_PUT;
              end else begin
                state_d = ST_ADD;
              end
            end
            gle_pkg::PH_MISS_CLR: begin
              cmd_o.restart = 1'b1;
              need_clr_d    = 1'b1;
              state_d       = ST_FLUSH;
            end
            gle_pkg::PH_FIN_PREF: begin
              csel_d  = gle_pkg::CS_END;
              phase_d = gle_pkg::PH_FIN_END;
              state_d = ST_PUT;
            end
            gle_pkg::PH_FIN_END: state_d = ST_RESID;
            default: state_d = ST_FLUSH;
          endcase
        end
      end
      ST_PROBE: state_d = ST_CHECK;
      ST_CHECK: begin
        if (sts_i.empty || (!sts_i.hit && sts_i.exhausted)) begin
          cmd_o.probe_miss = 1'b1;
          csel_d  = gle_pkg::CS_PREFIX;
          phase_d = gle_pkg::PH_MISS_PREF;
          state_d = ST_PUT;
        end else if (sts_i.hit) begin
          cmd_o.set_prefix_hit = 1'b1;
          state_d = ST_IDLE;
        end else begin
          cmd_o.probe_next = 1'b1;
          state_d = ST_PROBE;
        end
      end
      ST_ADD: begin
        cmd_o.dict_add = 1'b1;
        state_d = ST_FLUSH;
      end
      ST_RESID: begin
        if (sts_i.bc_nz) begin
          if (!sts_i.emit_stall) begin
            cmd_o.drain = 1'b1;
          end
        end else begin
          cmd_o.fin_cleanup = 1'b1;
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!sts_i.pend_valid) begin
          state_d = need_clr_q ? ST_CLEAR : ST_IDLE;
        end else if (!sts_i.fifo_full) begin
          cmd_o.flush = 1'b1;
          state_d = need_clr_q ? ST_CLEAR : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      phase_q    <= gle_pkg::PH_START;
      csel_q     <= gle_pkg::CS_PREFIX;
      need_clr_q <= 1'b1;
    end else begin
      state_q    <= state_d;
      phase_q    <= phase_d;
      csel_q     <= csel_d;
      need_clr_q <= need_clr_d;
    end
  end

endmodule

@@ hdl/gif_lzw_encoder.sv @@
// top level of the gif lzw encoder
//
//   channel  dir  handshake     payload
//   in_i     in   valid/ready   opcode, pixel_value
//   out_o    out  valid/ready   out_byte, is_last, end_of_image
//   cfg_i    in   valid/ready   min_code_size (always ready)
//
// pixel hit: decode, then probe and check per probe step; miss adds put, drain, add
// start, and a code-space wrap, sweep the dictionary: all DictSlots (8192 default)
// after reset the same sweep runs before the first item is taken
// output bytes go through a 4-entry queue plus one held byte; a full queue stalls
module gif_lzw_encoder #(
  parameter int unsigned DictSlots = gle_pkg::DICT_SLOTS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  gle_in_if.sink    in_i,
  gle_out_if.source out_o,
  gle_cfg_if.sink   cfg_i
);

  gle_pkg::cmd_t       cmd;
  gle_pkg::sts_t       sts;
  logic                fifo_full;
  logic                push;
  gle_pkg::out_entry_t push_data;
  gle_pkg::out_entry_t head;
  logic [3:0]          cfg_val;

  assign cfg_i.ready = 1'b1;
  assign cfg_val     = cfg_i.min_code_size;

  gle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  gle_datapath #(
    .DictSlots (DictSlots)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .min_code_size_i (cfg_val),
    .cfg_we_i        (cfg_i.valid && cfg_i.ready),
    .opcode_i        (in_i.opcode),
    .pixel_value_i   (in_i.pixel_value),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .fifo_full_i     (fifo_full),
    .push_o          (push),
    .push_data_o     (push_data)
  );

  gle_out_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (fifo_full),
    .valid_o     (out_o.valid),
    .ready_i     (out_o.ready),
    .data_o      (head)
  );

  assign out_o.out_byte     = head.out_byte;
  assign out_o.is_last      = head.is_last;
  assign out_o.end_of_image = head.end_of_image;

endmodule

@@ test/gle_tb_pkg.sv @@
// lzw encoder scoreboard: predicts the packed byte stream and checks results
package gle_tb_pkg;
  import gle_pkg::*;

  class lzw_scoreboard;
    logic [31:0] dict_mem [DICT_SLOTS];
    logic [3:0]  cfg_size;
    logic [11:0] prefix;
    bit          has_prefix;
    int unsigned free_code;
    int unsigned width;
    int unsigned limit;
    logic [31:0] acc;
    int unsigned nbits;
    bit          img_active;
    int unsigned depth;
    out_entry_t  bytes_due[$];
    out_entry_t  pend[$];
    int          errors;

    function new();
      cfg_size = DEPTH_RST;
      prefix = '0;
      has_prefix = 0;
      free_code = 0;
      width = 0;
      limit = 0;
      acc = '0;
      nbits = 0;
      img_active = 0;
      depth = 0;
      errors = 0;
      wipe();
    endfunction

    function void wipe();
      foreach (dict_mem[i]) dict_mem[i] = '1;
    endfunction

    function int unsigned hash_slot(logic [31:0] key);
      return (((key >> 12) ^ key) & 32'hFFFFF) % DICT_SLOTS;
    endfunction

    function int lookup(logic [31:0] key);
      int unsigned s;
      s = hash_slot(key);
      for (int n = 0; n < DICT_SLOTS; n++) begin
        if (dict_mem[s][31:12] == EMPTY_KEY) return -1;
        if (dict_mem[s][31:12] == key[19:0]) return int'(dict_mem[s][11:0]);
        s = (s + 1) % DICT_SLOTS;
      end
      return -1;
    endfunction

    function void insert(logic [31:0] key, int unsigned code);
      int unsigned s;
      s = hash_slot(key);
      for (int n = 0; n < DICT_SLOTS; n++) begin
        if (dict_mem[s][31:12] == EMPTY_KEY) begin
          dict_mem[s] = {key[19:0], code[11:0]};
          return;
        end
        s = (s + 1) % DICT_SLOTS;
      end
    endfunction

    function void push_byte(logic [7:0] b);
      out_entry_t e;
      e.out_byte = b;
      e.is_last = 0;
      e.end_of_image = 0;
      pend.push_back(e);
    endfunction

    function void pack_code(int unsigned code);
      acc |= (code & 32'hFFF) << (nbits & 31);
      nbits += width;
      while (nbits >= 8) begin
        push_byte(acc[7:0]);
        acc >>= 8;
        nbits -= 8;
      end
      if (free_code >= limit && width < MAX_WIDTH) begin
        width++;
        limit = 1 << width;
      end
    endfunction

    function void restart_codes();
      free_code = (1 << depth) + 2;
      width = depth + 1;
      limit = 1 << width;
    endfunction

    function void set_size(logic [3:0] v);
      cfg_size = v;
    endfunction

    // note an accepted input transfer
    function void note_input(logic [1:0] op, logic [7:0] pix_in);
      logic [31:0] key;
      int hit;
      int unsigned pix;
      bit fin;
      fin = 0;
      pend.delete();
      pix = pix_in;
      if (op == OP_START) begin
        depth = cfg_size < DEPTH_MIN ? DEPTH_MIN : (cfg_size > DEPTH_MAX ? DEPTH_MAX : cfg_size);
        img_active = 1;
        has_prefix = 0;
        prefix = '0;
        acc = '0;
        nbits = 0;
        restart_codes();
        push_byte(depth[7:0]);
        wipe();
        pack_code(1 << depth);
      end else if (op == OP_PIXEL && img_active) begin
        pix &= (1 << depth) - 1;
        if (!has_prefix) begin
          prefix = pix[11:0];
          has_prefix = 1;
        end else begin
          key = ({20'd0, prefix} << 8) | pix;
          hit = lookup(key);
          if (hit >= 0) prefix = hit[11:0];
          else begin
            pack_code(prefix);
            prefix = pix[11:0];
            if (free_code >= MAX_CODE) begin
              pack_code(1 << depth);
              restart_codes();
              wipe();
            end else begin
              insert(key, free_code);
              free_code++;
            end
          end
        end
      end else if (op == OP_FINISH && img_active) begin
        if (has_prefix) pack_code(prefix);
        pack_code((1 << depth) + 1);
        while (nbits > 0) begin
          push_byte(acc[7:0]);
          acc >>= 8;
          nbits = nbits >= 8 ? nbits - 8 : 0;
        end
        acc = '0;
        nbits = 0;
        has_prefix = 0;
        img_active = 0;
        fin = 1;
      end
      while (pend.size() > OUT_DEPTH) void'(pend.pop_back());
      if (pend.size() > 0) begin
        pend[pend.size() - 1].is_last = 1;
        pend[pend.size() - 1].end_of_image = fin;
      end
      foreach (pend[i]) bytes_due.push_back(pend[i]);
    endfunction

    // check one accepted output transfer
    function void check_output(out_entry_t got);
      out_entry_t want;
      if (bytes_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected byte %h last %b eoi %b",
          got.out_byte, got.is_last, got.end_of_image);
        return;
      end
      want = bytes_due.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp byte %h last %b eoi %b, got byte %h last %b eoi %b",
            want.out_byte, want.is_last, want.end_of_image,
            got.out_byte, got.is_last, got.end_of_image);
      end
    endfunction
  endclass
endpackage

@@ test/testbench.sv @@
// testbench top: drives pixel streams into the lzw encoder and checks its bytes
module testbench;
  import gle_pkg::*;
  import gle_tb_pkg::*;

  localparam int IdleLimit = 200000;
  localparam logic [1:0] OpUnused = 2'd3;

  logic clk_i = 0;
  logic rst_ni = 0;
  bit   calm = 0;
  int   idle_cycles = 0;

  gle_in_if  in_ch();
  gle_out_if out_ch();
  gle_cfg_if cfg_ch();

  lzw_scoreboard board = new();

  gif_lzw_encoder i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source),
    .cfg_i  (cfg_ch.sink)
  );

  always begin
    #4 clk_i = 1;
    #4 clk_i = 0;
  end

  initial begin
    in_ch.valid = 0;
    in_ch.opcode = OP_START;
    in_ch.pixel_value = '0;
    out_ch.ready = 0;
    cfg_ch.valid = 0;
    cfg_ch.min_code_size = '0;
  end

  // sink side with random stall bursts
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready)
        board.check_output('{out_ch.out_byte, out_ch.is_last, out_ch.end_of_image});
    end
  end

  initial begin
    int n;
    @(posedge clk_i);
    while (1) begin
      out_ch.ready <= 1;
      n = $urandom_range(1, 12);
      repeat (n) @(posedge clk_i);
      if (!calm) begin
        out_ch.ready <= 0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
  end

  // watchdog on cycles with no transfer
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_item(logic [1:0] op, logic [7:0] pix);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_ch.valid <= 1;
    in_ch.opcode <= op;
    in_ch.pixel_value <= pix;
    do @(posedge clk_i); while (!in_ch.ready);
    board.note_input(op, pix);
  endtask

  task automatic drain_all();
    in_ch.valid <= 0;
    while (board.bytes_due.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_size(logic [3:0] v);
    cfg_ch.valid <= 1;
    cfg_ch.min_code_size <= v;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 0;
    board.set_size(v);
  endtask

  task automatic rand_image(int npix, int unsigned span);
    send_item(OP_START, 8'($urandom));
    for (int i = 0; i < npix; i++) begin
      if ($urandom_range(0, 19) == 0) send_item(OpUnused, 8'($urandom));
      else send_item(OP_PIXEL, 8'($urandom_range(0, span)));
    end
    send_item(OP_FINISH, 8'($urandom));
  endtask

  initial begin
    logic [3:0] sizes [6] = '{4'd0, 4'd2, 4'd15, 4'd5, 4'd8, 4'd3};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    // directed: ignored items before any image, extremes, empty image
    send_item(OP_PIXEL, 8'hFF);
    send_item(OP_FINISH, 8'h00);
    send_item(OpUnused, 8'hAA);
    send_item(OP_START, 8'h00);
    send_item(OP_FINISH, 8'h00);
    send_item(OP_START, 8'h55);
    send_item(OP_PIXEL, 8'h00);
    send_item(OP_PIXEL, 8'hFF);
    send_item(OP_PIXEL, 8'hFF);
    send_item(OP_PIXEL, 8'hFF);
    send_item(OP_PIXEL, 8'h00);
    send_item(OP_START, 8'hFF);
    send_item(OP_PIXEL, 8'h80);
    send_item(OP_PIXEL, 8'h7F);
    send_item(OP_PIXEL, 8'h80);
    send_item(OP_PIXEL, 8'h7F);
    send_item(OP_FINISH, 8'hFF);
    send_item(OP_FINISH, 8'h00);
    drain_all();
    // size settings including clamped extremes; out-of-depth pixels get masked
    foreach (sizes[k]) begin
      write_size(sizes[k]);
      rand_image(6, 255);
      rand_image(8, 3);
      drain_all();
    end
    write_size(4'd8);
    calm = 1;
    rand_image(20, 255);
    rand_image(6, 1);
    drain_all();
    if (board.errors == 0 && board.bytes_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

@@ sim.f @@
+incdir+hdl
hdl/gle_pkg.sv
hdl/gle_if.sv
hdl/gle_out_fifo.sv
hdl/gle_datapath.sv
hdl/gle_ctrl.sv
hdl/gif_lzw_encoder.sv
test/gle_tb_pkg.sv
test/testbench.sv
